>>> design/wsrm_pkg.sv
// shared types and constants for the wildcard star regex matcher
// no dependencies; imported by every module of the matcher
`default_nettype none

package wsrm_pkg;

    localparam int MAX_TOKENS = 32;
    localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam int POS_W      = MAX_TOKENS + 1;
    localparam int CLOSE_LVLS = $clog2(POS_W);

    localparam logic [7:0] CH_ANY  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;

    typedef enum logic [1:0] {
        KIND_RESTART = 2'd0,
        KIND_APPEND  = 2'd1,
        KIND_TEXT    = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    // pattern view handed from the token store to the nfa
    typedef struct packed {
        logic [MAX_TOKENS-1:0] star_cur;
        logic [MAX_TOKENS-1:0] hit;
        logic [MAX_TOKENS-1:0] star_next;
        logic [CNT_W-1:0]      count_next;
        logic                  ovf_next;
    } pat_view_t;

endpackage

`default_nettype wire

>>> design/wildcard_star_regex_matcher_core.sv
// top level of the wildcard star regex matcher: input register, token store,
// nfa and result register; depends on wsrm_pkg, wsrm_token_store, wsrm_nfa,
// wsrm_result_reg
`default_nettype none

// Whole-string matcher for patterns of literal bytes, '.' (any byte) and '*'
// (zero or more of the previous token). Each input transfer carries a kind in
// tuser (0 restart text, 1 append pattern byte, 2 text byte, 3 clear pattern)
// and a byte in tdata; every input transfer yields exactly one output transfer
// with matched (text since the last restart matches the whole pattern) and a
// sticky overflow flag, set when a pattern byte was dropped as all 32 token
// slots were in use; only reset or a clear-pattern item clears it. A '*' that
// follows an unstarred token stars it and takes no slot; otherwise it is a
// literal. Load the pattern, then send a restart before the text. The block
// takes one item per clock cycle with no bubbles while the output side takes
// results; each result passes through the input and result registers. The
// critical path runs from the input register through the per-token byte
// compare and a six-level prefix network that closes the position set across
// starred tokens, into the position set and the result register. No clearing
// pass is needed after reset.
module wildcard_star_regex_matcher_core
    import wsrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_axis_tuser,   // [1:0] kind
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    // input register
    logic       in_vld_reg;
    logic       in_vld_next;
    kind_t      kind_reg;
    logic [7:0] byte_reg;

    logic       in_xfer;
    logic       fire;
    logic       res_can_take;
    logic       matched_next;
    pat_view_t  view;

    // an item is worked on when the result register can take its result
    assign fire          = in_vld_reg && res_can_take;
    assign s_axis_tready = !in_vld_reg || fire;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_vld_next   = in_xfer ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= kind_t'(s_axis_tuser);
            byte_reg <= s_axis_tdata;
        end
    end

    // pattern tokens, count and overflow; offers current and next pattern views
    wsrm_token_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (kind_reg),
        .data_byte (byte_reg),
        .view      (view)
    );

    // active position set, closure and match bit
    wsrm_nfa u_nfa (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .kind         (kind_reg),
        .view         (view),
        .matched_next (matched_next)
    );

    // result register toward the output side
    wsrm_result_reg u_res (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .matched_in (matched_next),
        .ovf_in     (view.ovf_next),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .can_take   (res_can_take),
        .out_data   (m_axis_tdata)
    );

    // every processed item leaves a result on offer in the next cycle
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tvalid)
        else $error("processed item produced no result");

    // an empty input register never blocks the input side
    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> s_axis_tready)
        else $error("input stalled with empty input register");

    // clearing the pattern drops the overflow flag in its own result
    a_clear_drops_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (kind_reg == KIND_CLEAR)) |=> !m_axis_tdata[1])
        else $error("overflow still set after pattern clear");

    // a stalled result is not overwritten by a new one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !fire)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> design/wsrm_token_store.sv
// token store: pattern lanes, token count and sticky overflow flag
// depends on wsrm_pkg
`default_nettype none

module wsrm_token_store
    import wsrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire kind_t      kind,
    input  wire logic [7:0] data_byte,
    output pat_view_t       view
);

    logic [7:0]            char_reg [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] any_reg;
    logic [MAX_TOKENS-1:0] star_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  ovf_reg;
    logic                  ovf_next;

    logic [CNT_W-1:0]      cnt_m1;
    logic [IDX_W-1:0]      last_idx;
    logic                  is_app;
    logic                  star_app;
    logic                  new_tok;
    logic [MAX_TOKENS-1:0] lane_new;
    logic [MAX_TOKENS-1:0] lane_star;

    always_comb
    begin
        cnt_m1   = count_reg - CNT_W'(1);
        last_idx = cnt_m1[IDX_W-1:0];
        is_app   = (kind == KIND_APPEND);
        star_app = is_app && (data_byte == CH_STAR) && (count_reg != '0)
                   && !star_reg[last_idx];
        new_tok  = is_app && !star_app && (count_reg < CNT_W'(MAX_TOKENS));

        count_next = count_reg;
        ovf_next   = ovf_reg;
        case (kind)
            KIND_CLEAR:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            KIND_APPEND:
            begin
                if (new_tok)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else if (!star_app)
                begin
                    ovf_next = 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    for (genvar k = 0; k < MAX_TOKENS; k++)
    begin : g_lane
        assign lane_new[k]  = new_tok && (count_reg == CNT_W'(k));
        assign lane_star[k] = star_app && (last_idx == IDX_W'(k));

        // lane payload, no reset: only lanes below the count are ever used
        always_ff @(posedge clk)
        begin
            if (fire && lane_new[k])
            begin
                char_reg[k] <= data_byte;
                any_reg[k]  <= (data_byte == CH_ANY);
                star_reg[k] <= 1'b0;
            end
            else if (fire && lane_star[k])
            begin
                star_reg[k] <= 1'b1;
            end
        end

        assign view.star_cur[k]  = star_reg[k] && (count_reg > CNT_W'(k));
        assign view.hit[k]       = (any_reg[k] || (char_reg[k] == data_byte))
                                   && (count_reg > CNT_W'(k));
        assign view.star_next[k] = ((star_reg[k] && !lane_new[k]) || lane_star[k])
                                   && (count_next > CNT_W'(k));
    end

    assign view.count_next = count_next;
    assign view.ovf_next   = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> design/wsrm_nfa.sv
// nfa position set with starred-token closure by a parallel prefix network
// depends on wsrm_pkg
`default_nettype none

module wsrm_nfa
    import wsrm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire kind_t     kind,
    input  wire pat_view_t view,
    output logic           matched_next
);

    // the set is kept already closed under the current pattern
    logic [POS_W-1:0]      closed_reg;
    logic [POS_W-1:0]      closed_next;
    logic [POS_W-1:0]      raw_next;
    logic [MAX_TOKENS-1:0] take;
    logic [POS_W-1:0]      gen;
    logic [POS_W-1:0]      prop;

    always_comb
    begin
        take = closed_reg[MAX_TOKENS-1:0] & view.hit;
        case (kind)
            KIND_RESTART, KIND_CLEAR:
            begin
                raw_next = POS_W'(1);
            end
            KIND_TEXT:
            begin
                raw_next = {1'b0, take & view.star_cur}
                         | {take & ~view.star_cur, 1'b0};
            end
            default:
            begin
                raw_next = closed_reg;
            end
        endcase

        // propagate into position j from j-1 across a starred token
        gen  = raw_next;
        prop = {view.star_next, 1'b0};
        for (int l = 0; l < CLOSE_LVLS; l++)
        begin
            gen  = gen | (prop & (gen << (1 << l)));
            prop = prop & (prop << (1 << l));
        end
        closed_next  = gen;
        matched_next = closed_next[view.count_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= POS_W'(1);
        end
        else if (fire)
        begin
            closed_reg <= closed_next;
        end
    end

endmodule

`default_nettype wire

>>> design/wsrm_result_reg.sv
// result register holding one finished result until the output transfer
// depends on wsrm_pkg
`default_nettype none

module wsrm_result_reg
    import wsrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic       matched_in,
    input  wire logic       ovf_in,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic            can_take,
    output logic [7:0]      out_data
);

    logic vld_reg;
    logic vld_next;
    logic matched_reg;
    logic ovf_reg;

    assign can_take = !vld_reg || out_ready;
    assign vld_next = fire ? 1'b1 : (out_ready ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            matched_reg <= matched_in;
            ovf_reg     <= ovf_in;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = {6'b0, ovf_reg, matched_reg};

endmodule

`default_nettype wire

>>> tb/tb_wildcard_star_regex_matcher_core.sv
// self-checking testbench for wildcard_star_regex_matcher_core: directed and random
// pattern/text streams checked against an in-bench nfa model of the matcher
// depends on wsrm_pkg and the matcher rtl
`default_nettype none

module tb_wildcard_star_regex_matcher_core;
    import wsrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run shaping: item count, idle percentage, and cycle-counted stretches and limits
    localparam int RANDOM_ITEMS = 550;
    localparam int IDLE_PCT     = 8;
    localparam int QUIET_FROM   = 300;    // stretch with no idling on either side
    localparam int QUIET_TO     = 450;
    localparam int HOLD_FROM    = 120;    // receiver holds off here so the block backs up
    localparam int HOLD_LEN     = 80;
    localparam int STALL_LIMIT  = 2000;   // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 8;      // drain margin after the last result

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } stim_item_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } match_result_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic [1:0] s_axis_tuser  = 2'd0;    // [1:0] kind
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [0] matched, [1] pattern_overflow, [7:2] zero

    wildcard_star_regex_matcher_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------------
    // matcher model: token store plus the set of live nfa positions
    // position pat_len is the accepting one
    // ---------------------------------------------------------------------
    logic [7:0]       pat_char [MAX_TOKENS];
    logic             pat_any  [MAX_TOKENS];
    logic             pat_star [MAX_TOKENS];
    int unsigned      pat_len   = 0;
    logic [POS_W-1:0] live_pos  = POS_W'(1);
    logic             ovf_seen  = 1'b0;

    // a live starred token also makes the position after it live;
    // walking upward lets chains of stars propagate in one pass
    function automatic logic [POS_W-1:0] star_closure(input logic [POS_W-1:0] set);
        for (int k = 0; k < pat_len; k++)
            if (set[k] && pat_star[k])
                set[k+1] = 1'b1;
        return set;
    endfunction

    function automatic match_result_t advance_matcher(input kind_t kind, input logic [7:0] b);
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] nxt;
        logic [POS_W-1:0] fin;
        match_result_t    res;
        case (kind)
            KIND_RESTART: live_pos = POS_W'(1);
            KIND_APPEND:
            begin
                // a star on an unstarred last token needs no slot, even when full
                if (b == CH_STAR && pat_len > 0 && !pat_star[pat_len-1])
                    pat_star[pat_len-1] = 1'b1;
                else if (pat_len >= MAX_TOKENS)
                    ovf_seen = 1'b1;
                else
                begin
                    pat_char[pat_len] = b;
                    pat_any[pat_len]  = (b == CH_ANY);
                    pat_star[pat_len] = 1'b0;
                    pat_len++;
                end
            end
            KIND_TEXT:
            begin
                cur = star_closure(live_pos);
                nxt = '0;
                for (int k = 0; k < pat_len; k++)
                    if (cur[k] && (pat_any[k] || pat_char[k] == b))
                    begin
                        if (pat_star[k])
                            nxt[k] = 1'b1;
                        else
                            nxt[k+1] = 1'b1;
                    end
                live_pos = nxt;
            end
            default:
            begin
                pat_len  = 0;
                ovf_seen = 1'b0;
                live_pos = POS_W'(1);
            end
        endcase
        fin          = star_closure(live_pos);
        res.matched  = fin[pat_len];
        res.overflow = ovf_seen;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus store and generators
    // ---------------------------------------------------------------------
    stim_item_t    pending_q [$];
    match_result_t verdict_q [$];
    int            mismatch_cnt = 0;

    task automatic push_item(input kind_t kind, input logic [7:0] b);
        stim_item_t it;
        it.kind = kind;
        it.data = b;
        pending_q.push_back(it);
    endtask

    // mostly a small alphabet so that text hits the pattern, sometimes any byte
    function automatic logic [7:0] pick_sym();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 22)
            return "a";
        else if (r < 40)
            return "b";
        else if (r < 52)
            return "c";
        else if (r < 64)
            return CH_ANY;
        else if (r < 72)
            return CH_STAR;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // clear, load a pattern built token by token, then one or two texts that
    // mostly follow the pattern, some of them with one byte broken or added
    task automatic gen_pattern_run(input bit force_long);
        int unsigned n_tok;
        int unsigned reps;
        int unsigned n_txt;
        logic [7:0]  tok_ch [40];
        bit          tok_st [40];
        logic [7:0]  txt [$];
        logic [7:0]  ch;
        n_tok = (force_long || $urandom_range(0, 11) == 0) ? $urandom_range(33, 38)
                                                           : $urandom_range(0, 7);
        push_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < n_tok; i++)
        begin
            ch = pick_sym();
            // a star here would star the previous token instead of being a literal
            if (ch == CH_STAR && i > 0 && !tok_st[i-1])
                ch = "b";
            tok_ch[i] = ch;
            tok_st[i] = ($urandom_range(0, 2) == 0) || (force_long && i == MAX_TOKENS - 1);
            push_item(KIND_APPEND, ch);
            if (tok_st[i])
                push_item(KIND_APPEND, CH_STAR);
        end
        n_txt = $urandom_range(1, 2);
        for (int t = 0; t < n_txt; t++)
        begin
            txt.delete();
            for (int i = 0; i < n_tok && i < MAX_TOKENS; i++)
            begin
                reps = tok_st[i] ? $urandom_range(0, 3) : 1;
                repeat (reps)
                    txt.push_back(tok_ch[i] == CH_ANY ? pick_sym() : tok_ch[i]);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                if (txt.size() > 0 && $urandom_range(0, 1) == 0)
                    txt[$urandom_range(0, txt.size() - 1)] = pick_sym();
                else
                    txt.push_back(pick_sym());
            end
            push_item(KIND_RESTART, 8'($urandom_range(0, 255)));
            foreach (txt[i])
                push_item(KIND_TEXT, txt[i]);
        end
    endtask

    // unstructured items: pattern edits mid-text, text without restart and the like
    task automatic gen_noise();
        repeat ($urandom_range(1, 6))
            push_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------------
    // sender: holds each transfer until taken, otherwise idles at random
    // ---------------------------------------------------------------------
    logic       in_taken = 1'b0;
    int         tx_cyc   = 0;
    stim_item_t tx_item;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            tx_cyc <= tx_cyc + 1;
            if (!s_axis_tvalid || in_taken)
            begin
                if (pending_q.size() != 0 &&
                    ((tx_cyc >= QUIET_FROM && tx_cyc < QUIET_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    tx_item = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= tx_item.kind;
                    s_axis_tdata  <= tx_item.data;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // receiver: random stalls, one quiet stretch and one long hold-off
    // ---------------------------------------------------------------------
    int rx_cyc = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cyc <= rx_cyc + 1;
            if (rx_cyc >= HOLD_FROM && rx_cyc < HOLD_FROM + HOLD_LEN)
                m_axis_tready <= 1'b0;
            else if (rx_cyc >= QUIET_FROM && rx_cyc < QUIET_TO)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------------
    // monitor: check result transfers first, since the one taken at this
    // edge cannot belong to an input taken at the same edge
    // ---------------------------------------------------------------------
    match_result_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result transfer, expected none, actual 0x%02h",
                             $time, m_axis_tdata);
                    mismatch_cnt++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== want.matched)
                    begin
                        $display("%0t ns: matched expected %0b actual %0b",
                                 $time, want.matched, m_axis_tdata[0]);
                        mismatch_cnt++;
                    end
                    if (m_axis_tdata[1] !== want.overflow)
                    begin
                        $display("%0t ns: pattern_overflow expected %0b actual %0b",
                                 $time, want.overflow, m_axis_tdata[1]);
                        mismatch_cnt++;
                    end
                    if (m_axis_tdata[7:2] !== 6'd0)
                    begin
                        $display("%0t ns: pad bits expected 0x00 actual 0x%02h",
                                 $time, m_axis_tdata[7:2]);
                        mismatch_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                verdict_q.push_back(advance_matcher(kind_t'(s_axis_tuser), s_axis_tdata));
            in_taken <= s_axis_tvalid && s_axis_tready;
        end
    end

    // watchdog: any transfer on either side counts as progress
    int stall_cnt = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus plan and end of run
    // ---------------------------------------------------------------------
    initial
    begin
        // empty pattern: matches only empty text; data ignored on clear and restart
        push_item(KIND_CLEAR, 8'hFF);
        push_item(KIND_TEXT, 8'h00);
        push_item(KIND_RESTART, 8'hAA);
        // leading star is literal, next one stars it, third one is literal again
        push_item(KIND_APPEND, CH_STAR);
        push_item(KIND_APPEND, CH_STAR);
        push_item(KIND_APPEND, CH_STAR);
        push_item(KIND_RESTART, 8'h00);
        push_item(KIND_TEXT, CH_STAR);
        push_item(KIND_TEXT, CH_STAR);
        // dot-star between literals, with extreme bytes swallowed by the dot
        push_item(KIND_CLEAR, 8'h55);
        push_item(KIND_APPEND, "a");
        push_item(KIND_APPEND, CH_ANY);
        push_item(KIND_APPEND, CH_STAR);
        push_item(KIND_APPEND, "b");
        push_item(KIND_RESTART, 8'hFF);
        push_item(KIND_TEXT, "a");
        push_item(KIND_TEXT, 8'hFF);
        push_item(KIND_TEXT, 8'h00);
        push_item(KIND_TEXT, "b");
        // pattern grows while text is live; extreme pattern bytes
        push_item(KIND_APPEND, 8'hFF);
        push_item(KIND_TEXT, 8'hFF);
        push_item(KIND_APPEND, 8'h00);
        push_item(KIND_TEXT, 8'h00);

        // random part: one overflowing pattern first, then mostly well-formed runs
        gen_pattern_run(1'b1);
        while (pending_q.size() < RANDOM_ITEMS + 23)
        begin
            if ($urandom_range(0, 99) < 78)
                gen_pattern_run(1'b0);
            else
                gen_noise();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
